/* rtl/scbp_pkg.sv */
// Shared types and codes for the size-class buffer pool.
// Holds the item, result, action, status and sequencer state types.
// No dependencies; every other file of the block imports it.
`default_nettype none

package scbp_pkg;

    // Width of a buffer handle on the ports and in the stack memory.
    localparam int HANDLE_W = 10;
    // Width of one configuration register and of the register index.
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    // Number of pools that have configuration registers.
    localparam int CFG_POOLS  = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_0 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_1 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_2 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_3 = 3'd7;

    typedef enum logic [1:0] {
        ACT_INIT = 2'd0,
        ACT_GET  = 2'd1,
        ACT_FREE = 2'd2,
        ACT_NONE = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_BUF   = 3'd1,
        ST_FULL     = 3'd2,
        ST_NO_MATCH = 3'd3,
        ST_NEG      = 3'd4
    } t_status;

    // Input item; the last field sits in the lowest bits.
    typedef struct packed {
        logic [7:0]          ref_count;
        logic [15:0]         size_tag;
        logic [HANDLE_W-1:0] handle;
        logic [15:0]         req_size;
        t_action             action;
    } t_item;

    // Result item; the last field sits in the lowest bits.
    typedef struct packed {
        logic [1:0]          pool_index;
        logic signed [8:0]   new_ref_count;
        logic [HANDLE_W-1:0] out_handle;
        t_status             status;
    } t_result;

    // Sequencer states.
    typedef enum logic [3:0] {
        SQ_IDLE   = 4'b0001,
        SQ_GET_RD = 4'b0010,
        SQ_INIT   = 4'b0100,
        SQ_HOLD   = 4'b1000
    } t_state;

endpackage

`default_nettype wire

/* rtl/scbp_stack_mem.sv */
// Handle stack memory shared by all pools: one port, registered read data.
// Depends on scbp_pkg for the handle width.
`default_nettype none

module scbp_stack_mem
    import scbp_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic                i_clk,
    input  wire logic                i_we,
    input  wire logic                i_re,
    input  wire logic [AW-1:0]       i_addr,
    input  wire logic [HANDLE_W-1:0] i_wdata,
    output logic      [HANDLE_W-1:0] o_rdata
);

    logic [HANDLE_W-1:0] r_mem [DEPTH];
    logic [HANDLE_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    // Read port; the read data is registered.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/scbp_ctrl.sv */
// Pool sequencer: per-pool top, limit and size registers, pool match,
// init sweep of the stack memory and the output register.
// Depends on scbp_pkg; drives scbp_stack_mem through its port signals.
`default_nettype none

module scbp_ctrl
    import scbp_pkg::*;
#(
    parameter int NUM_POOLS  = 4,
    parameter int POOL_DEPTH = 256,
    parameter int AW         = 10
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Input item channel.
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire t_item               i_item,
    // Result channel.
    output logic                     o_valid,
    input  wire logic                i_out_ready,
    output t_result                  o_res,
    // Pool setup as seen by init.
    input  wire logic [15:0]         i_cfg_size  [NUM_POOLS],
    input  wire logic [8:0]          i_cfg_count [NUM_POOLS],
    // Stack memory port.
    output logic                     o_mem_we,
    output logic                     o_mem_re,
    output logic [AW-1:0]            o_mem_addr,
    output logic [HANDLE_W-1:0]      o_mem_wdata,
    input  wire logic [HANDLE_W-1:0] i_mem_rdata
);

    localparam int PW = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
    localparam int SW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CW = $clog2(POOL_DEPTH + 1);

    t_state          r_state, n_state;
    logic [CW-1:0]   r_top   [NUM_POOLS];
    logic [CW-1:0]   r_limit [NUM_POOLS];
    logic [15:0]     r_size  [NUM_POOLS];
    logic [PW-1:0]   r_pool;
    logic [SW-1:0]   r_slot;
    logic [AW-1:0]   r_addr;
    logic [1:0]      r_get_pidx;
    t_result         r_res;
    t_result         r_out, n_out;
    logic            r_out_valid, n_out_valid;

    logic            accept;
    logic            slot_free;
    logic [NUM_POOLS-1:0] get_hit, free_hit, over_lim;
    logic [PW-1:0]   get_sel, free_sel;
    logic            get_any, free_any;
    logic [CW-1:0]   get_top, free_top, free_lim;
    logic            push_ok, do_push, do_get;
    logic [AW-1:0]   get_addr, free_addr;
    logic            sweep_last, sweep_we;
    t_result         imm_res, fin_res;
    logic            imm_done, fin_valid;

    // Base address of a pool's stack in the shared memory.
    function automatic logic [AW-1:0] pool_base(input logic [PW-1:0] p);
        int b;
        b = int'(p) * POOL_DEPTH;
        return AW'(b);
    endfunction

    // Buffer count of a pool after capping at the stack depth.
    function automatic logic [CW-1:0] cap_count(input logic [8:0] c);
        logic [CW-1:0] v;
        if (32'(c) > 32'(POOL_DEPTH)) begin
            v = CW'(POOL_DEPTH);
        end else begin
            v = CW'(c);
        end
        return v;
    endfunction

    // Handle written by init: the memory address, kept to handle width.
    function automatic logic [HANDLE_W-1:0] addr_handle(input logic [AW-1:0] a);
        logic [31:0] t;
        t = 32'(a);
        return t[HANDLE_W-1:0];
    endfunction

    assign accept    = i_valid && (r_state == SQ_IDLE);
    assign slot_free = !r_out_valid || i_out_ready;

    // Pool match: first non-empty pool that fits a get, first pool whose size equals a tag.
    always_comb begin
        get_sel  = '0;
        free_sel = '0;
        for (int p = 0; p < NUM_POOLS; p++) begin
            get_hit[p]  = (i_item.req_size <= r_size[p]) && (r_top[p] != '0);
            free_hit[p] = (i_item.size_tag == r_size[p]);
            over_lim[p] = (r_top[p] > r_limit[p]);
        end
        for (int p = NUM_POOLS - 1; p >= 0; p--) begin
            if (get_hit[p]) begin
                get_sel = PW'(p);
            end
            if (free_hit[p]) begin
                free_sel = PW'(p);
            end
        end
    end

    assign get_any   = |get_hit;
    assign free_any  = |free_hit;
    assign get_top   = r_top[get_sel];
    assign free_top  = r_top[free_sel];
    assign free_lim  = r_limit[free_sel];
    assign push_ok   = (free_top < free_lim) && (32'(free_top) < 32'(POOL_DEPTH));
    assign get_addr  = pool_base(get_sel) + AW'(get_top - CW'(1));
    assign free_addr = pool_base(free_sel) + AW'(free_top);

    assign do_get  = accept && (i_item.action == ACT_GET) && get_any;
    assign do_push = accept && (i_item.action == ACT_FREE) && (i_item.ref_count == 8'd1)
                     && free_any && push_ok;

    // Init sweep position.
    assign sweep_last = (r_pool == PW'(NUM_POOLS - 1)) && (r_slot == SW'(POOL_DEPTH - 1));
    assign sweep_we   = (r_state == SQ_INIT) && (CW'(r_slot) < r_limit[r_pool])
                        && (32'(r_slot) < 32'(POOL_DEPTH));

    // Stack memory access.
    always_comb begin
        o_mem_we    = do_push || sweep_we;
        o_mem_re    = do_get;
        o_mem_wdata = i_item.handle;
        o_mem_addr  = free_addr;
        if (r_state == SQ_INIT) begin
            o_mem_addr  = r_addr;
            o_mem_wdata = addr_handle(r_addr);
        end else if (i_item.action == ACT_GET) begin
            o_mem_addr = get_addr;
        end
    end

    // Result of an item that finishes in the cycle it is accepted.
    always_comb begin
        imm_res = '{pool_index: 2'd0, new_ref_count: 9'sd0,
                    out_handle: '0, status: ST_OK};
        imm_done = accept;
        case (i_item.action)
            ACT_INIT: begin
                imm_done = 1'b0;
            end
            ACT_GET: begin
                imm_done = accept && !get_any;
                imm_res.status = ST_NO_BUF;
            end
            ACT_FREE: begin
                if (i_item.ref_count == 8'd0) begin
                    imm_res.status        = ST_NEG;
                    imm_res.new_ref_count = -9'sd1;
                end else if (i_item.ref_count > 8'd1) begin
                    imm_res.new_ref_count = $signed({1'b0, i_item.ref_count} - 9'd1);
                end else if (!free_any) begin
                    imm_res.status = ST_NO_MATCH;
                end else begin
                    imm_res.pool_index = 2'(free_sel);
                    imm_res.status     = push_ok ? ST_OK : ST_FULL;
                end
            end
            default: begin
                imm_res.status = ST_OK;
            end
        endcase
    end

    // Result that is ready to leave in this cycle, whatever its source.
    always_comb begin
        fin_valid = 1'b0;
        fin_res   = '{pool_index: 2'd0, new_ref_count: 9'sd0,
                      out_handle: '0, status: ST_OK};
        unique case (r_state)
            SQ_IDLE: begin
                fin_valid = imm_done;
                fin_res   = imm_res;
            end
            SQ_GET_RD: begin
                fin_valid = 1'b1;
                fin_res   = '{pool_index: r_get_pidx, new_ref_count: 9'sd1,
                              out_handle: i_mem_rdata, status: ST_OK};
            end
            SQ_INIT: begin
                fin_valid = sweep_last;
            end
            SQ_HOLD: begin
                fin_valid = 1'b1;
                fin_res   = r_res;
            end
            default: begin
                fin_valid = 1'b0;
            end
        endcase
    end

    // Next state and output register.
    always_comb begin
        n_state     = r_state;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        if (fin_valid) begin
            if (slot_free) begin
                n_out       = fin_res;
                n_out_valid = 1'b1;
                n_state     = SQ_IDLE;
            end else begin
                n_state = SQ_HOLD;
            end
        end else if (accept && (i_item.action == ACT_INIT)) begin
            n_state = SQ_INIT;
        end else if (do_get) begin
            n_state = SQ_GET_RD;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SQ_IDLE;
            r_out_valid <= 1'b0;
            for (int p = 0; p < NUM_POOLS; p++) begin
                r_top[p]   <= '0;
                r_limit[p] <= '0;
                r_size[p]  <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (accept && (i_item.action == ACT_INIT)) begin
                for (int p = 0; p < NUM_POOLS; p++) begin
                    r_top[p]   <= cap_count(i_cfg_count[p]);
                    r_limit[p] <= cap_count(i_cfg_count[p]);
                    r_size[p]  <= i_cfg_size[p];
                end
            end else if (do_get) begin
                r_top[get_sel] <= get_top - CW'(1);
            end else if (do_push) begin
                r_top[free_sel] <= free_top + CW'(1);
            end
        end
    end

    // Payload registers and sweep counters.
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (fin_valid && !slot_free) begin
            r_res <= fin_res;
        end
        if (do_get) begin
            r_get_pidx <= 2'(get_sel);
        end
        if (accept && (i_item.action == ACT_INIT)) begin
            r_pool <= '0;
            r_slot <= '0;
            r_addr <= '0;
        end else if (r_state == SQ_INIT) begin
            r_addr <= r_addr + AW'(1);
            if (r_slot == SW'(POOL_DEPTH - 1)) begin
                r_slot <= '0;
                r_pool <= r_pool + PW'(1);
            end else begin
                r_slot <= r_slot + SW'(1);
            end
        end
    end

    assign o_ready = (r_state == SQ_IDLE);
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    // A read result is only awaited after a get was issued to the memory.
    a_get_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SQ_GET_RD) |-> $past(o_mem_re))
        else $error("get read state without a memory read");

    // The stack is written only by the init sweep or an accepted free.
    a_write_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_we |-> ((r_state == SQ_INIT) || (accept && (i_item.action == ACT_FREE))))
        else $error("stack written outside init or free");

    // A held result means the output register is still occupied.
    a_hold_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SQ_HOLD) |-> r_out_valid)
        else $error("result held while output register is empty");

    // No pool ever holds more handles than init gave it.
    a_top_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        over_lim == '0)
        else $error("pool stack top above its limit");

endmodule

`default_nettype wire

/* rtl/size_class_buffer_pool_top.sv */
// Size-class buffer pool: a get does the match, then the stack read;
// a free, a failed get or an undefined action is done in the match step alone.
// An init runs the one-entry-per-cycle sweep over every pool's stack
// that writes the handles into the single-port stack memory.
// One item is in work at a time; a result waits in the output register.
// Synchronous active-low reset empties all pools and clears the state and configuration registers.
`default_nettype none

module size_class_buffer_pool_top
    import scbp_pkg::*;
#(
    parameter int NUM_POOLS  = 4,
    parameter int POOL_DEPTH = 256
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Configuration write port.
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // Input stream.
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [1:0] action, [17:2] req_size, [27:18] handle, [43:28] size_tag,
    // [51:44] ref_count, [55:52] zero
    input  wire logic [55:0]           s_axis_tdata,
    // Result stream.
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [2:0] status, [12:3] out_handle, [21:13] new_ref_count, [23:22] pool_index
    output logic [23:0]                m_axis_tdata
);

    localparam int STORE_DEPTH = NUM_POOLS * POOL_DEPTH;
    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    logic [15:0]         r_pool_size  [CFG_POOLS];
    logic [8:0]          r_pool_count [CFG_POOLS];
    logic [15:0]         cfg_size     [NUM_POOLS];
    logic [8:0]          cfg_count    [NUM_POOLS];
    t_item               item;
    t_result             res;
    logic                mem_we, mem_re;
    logic [AW-1:0]       mem_addr;
    logic [HANDLE_W-1:0] mem_wdata, mem_rdata;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < CFG_POOLS; p++) begin
                r_pool_size[p]  <= '0;
                r_pool_count[p] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SIZE_0:  r_pool_size[0]  <= i_cfg_data;
                REG_SIZE_1:  r_pool_size[1]  <= i_cfg_data;
                REG_SIZE_2:  r_pool_size[2]  <= i_cfg_data;
                REG_SIZE_3:  r_pool_size[3]  <= i_cfg_data;
                REG_COUNT_0: r_pool_count[0] <= i_cfg_data[8:0];
                REG_COUNT_1: r_pool_count[1] <= i_cfg_data[8:0];
                REG_COUNT_2: r_pool_count[2] <= i_cfg_data[8:0];
                REG_COUNT_3: r_pool_count[3] <= i_cfg_data[8:0];
                default:     r_pool_size[0]  <= r_pool_size[0];
            endcase
        end
    end

    // Pools without registers are set up empty with size zero.
    always_comb begin
        for (int p = 0; p < NUM_POOLS; p++) begin
            cfg_size[p]  = '0;
            cfg_count[p] = '0;
            if (p < CFG_POOLS) begin
                cfg_size[p]  = r_pool_size[p % CFG_POOLS];
                cfg_count[p] = r_pool_count[p % CFG_POOLS];
            end
        end
    end

    assign item         = s_axis_tdata[$bits(t_item)-1:0];
    assign m_axis_tdata = res;

    scbp_ctrl #(
        .NUM_POOLS  (NUM_POOLS),
        .POOL_DEPTH (POOL_DEPTH),
        .AW         (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_item      (item),
        .o_valid     (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_res       (res),
        .i_cfg_size  (cfg_size),
        .i_cfg_count (cfg_count),
        .o_mem_we    (mem_we),
        .o_mem_re    (mem_re),
        .o_mem_addr  (mem_addr),
        .o_mem_wdata (mem_wdata),
        .i_mem_rdata (mem_rdata)
    );

    scbp_stack_mem #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_stack_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

endmodule

`default_nettype wire

/* sim/size_class_buffer_pool_top_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for size_class_buffer_pool_top: directed and random pool traffic,
// with every reply checked against a cycle-free predictor of the pools.
// Depends on scbp_pkg and size_class_buffer_pool_top; reads no files.

module size_class_buffer_pool_top_tb;
    import scbp_pkg::*;

    localparam int NPOOLS      = 4;
    localparam int DEPTH       = 256;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;

    // A buffer handed out by a get, remembered so it can be returned later.
    typedef struct {
        logic [HANDLE_W-1:0] handle;
        logic [15:0]         size;
    } t_lent;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [1:0] action, [17:2] req_size, [27:18] handle, [43:28] size_tag,
    // [51:44] ref_count, [55:52] zero
    logic [55:0]           s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [2:0] status, [12:3] out_handle, [21:13] new_ref_count, [23:22] pool_index
    logic [23:0]           m_axis_tdata;

    // Shadow copy of the registers and of the pool state.
    logic [15:0]         reg_size       [NPOOLS];
    logic [8:0]          reg_count      [NPOOLS];
    logic [HANDLE_W-1:0] stack_mem      [NPOOLS*DEPTH];
    logic [8:0]          stack_fill     [NPOOLS];
    logic [8:0]          pool_cap       [NPOOLS];
    logic [15:0]         pool_size_live [NPOOLS];

    t_result     replies_due [$];
    t_lent       lent_buffers [$];
    int unsigned error_count  = 0;
    int unsigned quiet_cycles = 0;
    bit          tx_idle_on   = 1'b1;
    bit          rx_idle_on   = 1'b1;
    int unsigned rx_hold      = 0;

    always #10 i_clk = ~i_clk;

    size_class_buffer_pool_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Works out the reply to one accepted item and updates the shadow pools.
    function automatic t_result compute_pool_reply(input t_item it);
        t_result     r;
        int unsigned cnt;
        int          h;
        r = '0;
        case (it.action)
            ACT_INIT: begin
                lent_buffers.delete();
                for (int p = 0; p < NPOOLS; p++) begin
                    cnt = (reg_count[p] > DEPTH) ? DEPTH : reg_count[p];
                    for (int s = 0; s < cnt; s++) begin
                        h = p * DEPTH + s;
                        stack_mem[h] = h[HANDLE_W-1:0];
                    end
                    stack_fill[p]     = cnt[8:0];
                    pool_cap[p]       = cnt[8:0];
                    pool_size_live[p] = reg_size[p];
                end
            end
            ACT_GET: begin
                r.status = ST_NO_BUF;
                for (int p = 0; p < NPOOLS; p++) begin
                    if (it.req_size <= pool_size_live[p] && stack_fill[p] != 0) begin
                        stack_fill[p]   = stack_fill[p] - 9'd1;
                        r.out_handle    = stack_mem[p * DEPTH + stack_fill[p]];
                        r.new_ref_count = 9'sd1;
                        r.pool_index    = p[1:0];
                        r.status        = ST_OK;
                        lent_buffers.push_back('{r.out_handle, pool_size_live[p]});
                        break;
                    end
                end
            end
            ACT_FREE: begin
                if (it.ref_count == 8'd0) begin
                    r.status        = ST_NEG;
                    r.new_ref_count = -9'sd1;
                end else if (it.ref_count > 8'd1) begin
                    r.new_ref_count = {1'b0, it.ref_count - 8'd1};
                end else begin
                    // Last reference gone: return the handle to the first pool of equal size.
                    r.status = ST_NO_MATCH;
                    for (int p = 0; p < NPOOLS; p++) begin
                        if (it.size_tag == pool_size_live[p]) begin
                            r.pool_index = p[1:0];
                            if (stack_fill[p] < pool_cap[p] && stack_fill[p] < DEPTH) begin
                                stack_mem[p * DEPTH + stack_fill[p]] = it.handle;
                                stack_fill[p] = stack_fill[p] + 9'd1;
                                r.status      = ST_OK;
                            end else begin
                                r.status = ST_FULL;
                            end
                            break;
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_item make_item(input t_action act, input logic [15:0] req,
                                        input logic [HANDLE_W-1:0] hnd,
                                        input logic [15:0] tag, input logic [7:0] refs);
        t_item it;
        it.action    = act;
        it.req_size  = req;
        it.handle    = hnd;
        it.size_tag  = tag;
        it.ref_count = refs;
        return it;
    endfunction

    function automatic logic [15:0] pick_pool_size();
        int unsigned r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return 16'd0;
            1:       return 16'hFFFF;
            // A small set of common sizes so that pools often share a size.
            2, 3, 4: return 16'd64 << $urandom_range(0, 4);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [8:0] pick_pool_count();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 2)
            return 9'd0;
        else if (r < 5)
            return 9'd256;
        else
            return 9'($urandom_range(1, 12));
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // One register write, taken at the next rising edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        // Size registers sit at indexes 0-3 and count registers at 4-7.
        if (idx < REG_COUNT_0)
            reg_size[idx[1:0]] = val;
        else
            reg_count[idx[1:0]] = val[8:0];
    endtask

    task automatic configure_pools(input logic [15:0] sizes [NPOOLS],
                                   input logic [8:0] counts [NPOOLS]);
        for (int p = 0; p < NPOOLS; p++) begin
            write_reg(REG_SIZE_0 + CFG_IDX_W'(p), sizes[p]);
            write_reg(REG_COUNT_0 + CFG_IDX_W'(p), {7'd0, counts[p]});
        end
    endtask

    // Offers one item until the block takes it, then records its expected reply.
    task automatic send_item(input t_item it);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9) - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, it};
        do @(posedge i_clk); while (!s_axis_tready);
        replies_due.push_back(compute_pool_reply(it));
    endtask

    // Stops offering items and waits until every reply has come back.
    task automatic wait_all_replies();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
    endtask

    // Right after reset every pool is empty and every size is zero.
    task automatic test_reset_state();
        send_item(make_item(ACT_GET, 16'd0, '0, 16'd0, 8'd0));
        send_item(make_item(ACT_FREE, 16'd0, 10'd1023, 16'd0, 8'd1));
        send_item(make_item(ACT_FREE, 16'd0, 10'd7, 16'd0, 8'd0));
        send_item(make_item(ACT_FREE, 16'd0, 10'd7, 16'd0, 8'd5));
        send_item(make_item(ACT_NONE, 16'd0, '0, 16'd0, 8'd0));
        wait_all_replies();
    endtask

    // Hand-picked pools: a full-depth pool, an empty one sharing a size with the next,
    // and a single-buffer pool at the largest size.
    task automatic test_directed_pools();
        logic [15:0] sizes  [NPOOLS];
        logic [8:0]  counts [NPOOLS];
        sizes  = '{16'd0, 16'd64, 16'd64, 16'hFFFF};
        counts = '{9'd256, 9'd0, 9'd3, 9'd1};
        configure_pools(sizes, counts);
        send_item(make_item(ACT_INIT, 16'd0, '0, 16'd0, 8'd0));
        send_item(make_item(ACT_GET, 16'd0, '0, 16'd0, 8'd0));
        send_item(make_item(ACT_GET, 16'd64, '0, 16'd0, 8'd0));
        send_item(make_item(ACT_GET, 16'hFFFF, '0, 16'd0, 8'd0));
        send_item(make_item(ACT_GET, 16'hFFFF, '0, 16'd0, 8'd0));
        send_item(make_item(ACT_FREE, 16'd0, 10'd1023, 16'hFFFF, 8'd1));
        send_item(make_item(ACT_FREE, 16'd0, 10'd5, 16'hFFFF, 8'd1));
        // The empty pool of size 64 comes first, so the free stops there as full.
        send_item(make_item(ACT_FREE, 16'd0, 10'd514, 16'd64, 8'd1));
        send_item(make_item(ACT_FREE, 16'd0, 10'd514, 16'd7, 8'd1));
        send_item(make_item(ACT_FREE, 16'd0, 10'd3, 16'd64, 8'd255));
        send_item(make_item(ACT_FREE, 16'd0, 10'd3, 16'd64, 8'd0));
        send_item(make_item(ACT_NONE, 16'hFFFF, 10'd1023, 16'hFFFF, 8'd255));
        send_item(make_item(ACT_GET, 16'hFFFF, '0, 16'd0, 8'd0));
        wait_all_replies();
    endtask

    // New pool setup, then mostly gets and returns of lent buffers, with some noise.
    task automatic test_random_traffic(input int unsigned n_items, input bit extreme);
        logic [15:0] sizes  [NPOOLS];
        logic [8:0]  counts [NPOOLS];
        int unsigned done_items, r, idx, p;
        t_item       it;
        wait_all_replies();
        for (int q = 0; q < NPOOLS; q++) begin
            sizes[q]  = pick_pool_size();
            counts[q] = extreme ? 9'd256 : pick_pool_count();
        end
        if (extreme) begin
            sizes[0] = 16'd0;
            sizes[1] = 16'hFFFF;
            sizes[3] = 16'hFFFF;
        end
        configure_pools(sizes, counts);
        send_item(make_item(ACT_INIT, 16'd0, '0, 16'd0, 8'd0));
        done_items = 0;
        while (done_items < n_items) begin
            it = make_item(ACT_NONE, 16'($urandom_range(0, 65535)),
                           HANDLE_W'($urandom_range(0, 1023)),
                           16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
            r  = $urandom_range(0, 99);
            if (r < 2) begin
                it.action = ACT_INIT;
            end else if (r < 47) begin
                it.action = ACT_GET;
                p = $urandom_range(0, NPOOLS - 1);
                if ($urandom_range(0, 3) != 0)
                    it.req_size = 16'($urandom_range(0, pool_size_live[p]));
            end else if (r < 85 && lent_buffers.size() != 0) begin
                // Return a buffer that is really out, usually dropping its last reference.
                it.action   = ACT_FREE;
                idx         = $urandom_range(0, lent_buffers.size() - 1);
                it.handle   = lent_buffers[idx].handle;
                it.size_tag = lent_buffers[idx].size;
                if ($urandom_range(0, 4) != 0) begin
                    it.ref_count = 8'd1;
                    lent_buffers.delete(idx);
                end else if (it.ref_count < 8'd2) begin
                    it.ref_count = 8'd2;
                end
            end else if (r < 97) begin
                it.action = ACT_FREE;
                if ($urandom_range(0, 1) != 0)
                    it.ref_count = 8'($urandom_range(0, 1));
                if ($urandom_range(0, 1) != 0)
                    it.size_tag = pool_size_live[$urandom_range(0, NPOOLS - 1)];
            end
            send_item(it);
            if (it.action != ACT_NONE)
                done_items++;
        end
    endtask

    // The result side holds off for a long stretch while items keep coming.
    task automatic test_output_stall();
        wait_all_replies();
        rx_hold = HOLD_CYCLES;
        for (int k = 0; k < 16; k++) begin
            if (k % 2 == 0)
                send_item(make_item(ACT_GET, 16'd0, '0, 16'd0, 8'd0));
            else
                send_item(make_item(ACT_FREE, 16'd0, HANDLE_W'(k), 16'd0, 8'd200));
        end
    endtask

    // Result side: ready drops in random bursts, or for a requested long hold.
    initial begin : result_ready_driver
        int unsigned gap;
        gap = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold != 0) begin
                rx_hold = rx_hold - 1;
                m_axis_tready <= 1'b0;
            end else if (gap != 0) begin
                gap = gap - 1;
                m_axis_tready <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
                gap = $urandom_range(0, 8);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Each reply transfer is compared with the oldest outstanding expectation.
    always @(posedge i_clk) begin : reply_checker
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata);
            if (replies_due.size() == 0) begin
                report_mismatch("unexpected reply, status", got.status, -1);
            end else begin
                want = replies_due.pop_front();
                if (got.status != want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.out_handle != want.out_handle)
                    report_mismatch("out_handle", got.out_handle, want.out_handle);
                if (got.new_ref_count != want.new_ref_count)
                    report_mismatch("new_ref_count", got.new_ref_count, want.new_ref_count);
                if (got.pool_index != want.pool_index)
                    report_mismatch("pool_index", got.pool_index, want.pool_index);
            end
        end
    end

    // Ends the run when no transfer happens on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("[size_class_buffer_pool_top] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Test sequence.
    initial begin
        for (int p = 0; p < NPOOLS; p++) begin
            reg_size[p]       = '0;
            reg_count[p]      = '0;
            stack_fill[p]     = '0;
            pool_cap[p]       = '0;
            pool_size_live[p] = '0;
        end
        for (int k = 0; k < NPOOLS * DEPTH; k++)
            stack_mem[k] = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_directed_pools();
        test_random_traffic(150, 1'b1);
        for (int k = 0; k < 4; k++)
            test_random_traffic(150, 1'b0);
        test_output_stall();
        // Last part runs at full rate on both sides.
        wait_all_replies();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_random_traffic(150, 1'b0);

        wait_all_replies();
        repeat (20) @(posedge i_clk);
        if (replies_due.size() != 0)
            report_mismatch("replies never seen", replies_due.size(), 0);
        if (error_count == 0)
            $display("[size_class_buffer_pool_top] OK");
        else
            $display("[size_class_buffer_pool_top] ERROR");
        $finish;
    end

endmodule

/* sim.f */
rtl/scbp_pkg.sv
rtl/scbp_stack_mem.sv
rtl/scbp_ctrl.sv
rtl/size_class_buffer_pool_top.sv
sim/size_class_buffer_pool_top_tb.sv
